// ----- src/assert_macros.svh -----
// Assertion macros used by the port checker file of this block.
// Clocked on i_clk; the reset-gated form is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included
`define ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/iaf_pkg.sv -----
// Types and constants for the integer-to-ASCII formatter.
// No dependencies; used by the top level and its checker.
package iaf_pkg;

    // Format selector codes
    localparam logic [1:0] FUNC_DEC    = 2'd0;
    localparam logic [1:0] FUNC_BIN    = 2'd1;
    localparam logic [1:0] FUNC_HEX    = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Character codes
    localparam logic [7:0] ASCII_ZERO        = 8'd48;
    localparam logic [7:0] ASCII_LETTER_BASE = 8'd55;
    localparam logic [7:0] ASCII_MINUS       = 8'd45;
    localparam logic [7:0] ASCII_NINE        = 8'd57;
    localparam logic [7:0] ASCII_UPPER_A     = 8'd65;
    localparam logic [7:0] ASCII_UPPER_F     = 8'd70;

    // Input request: one number to format
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
    } t_in_req;

    // Output request: one character
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_out_req;

endpackage

// ----- src/integer_to_ascii_formatter.sv -----
// Integer-to-ASCII formatter: signed decimal, binary or uppercase hex text,
// one character per output request. Depends on iaf_pkg.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in_req)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_req)
//
// Steps per number (W = VALUE_WIDTH, D = decimal digits of 2^W-1):
//   decimal: load, shift-add-3 over the W bits, then emit over D digits (after '-' if negative)
//   binary : load, then emit over the W bits; hex: load, then emit over ceil(W/4) digits
// The emit steps walk one digit a cycle through the shift register, skipping
// leading zeros, and pause whenever the output register is held by i_out_stall.
// Reset is synchronous and clears the state and the output valid.
module integer_to_ascii_formatter
    import iaf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    localparam int NDIG  = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int SH_W  = NDIG * 4;
    localparam int HEX_W = ((VALUE_WIDTH + 3) / 4) * 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [SH_W-1:0]        r_sh, n_sh;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_bin_mode, n_bin_mode;
    logic                   r_neg, n_neg;
    logic                   r_seen, n_seen;
    logic                   r_out_valid, n_out_valid;
    t_out_req               r_out, n_out;

    logic [VALUE_WIDTH-1:0] v_in;
    logic [SH_W-1:0]        adj;
    logic [3:0]             top_dig;
    logic                   is_last;
    logic                   out_free;
    logic [7:0]             dig_char;

    assign v_in     = VALUE_WIDTH'(i_in_data.value);
    assign top_dig  = r_sh[SH_W-1 -: 4];
    assign is_last  = (r_cnt == CNT_W'(1));
    assign out_free = !r_out_valid || !i_out_stall;

    // Shift-add-3 correction on every BCD digit
    always_comb begin
        adj = r_sh;
        for (int k = 0; k < NDIG; k++) begin
            if (r_sh[4*k+3 -: 4] >= 4'd5) begin
                adj[4*k+3 -: 4] = r_sh[4*k+3 -: 4] + 4'd3;
            end
        end
    end

    // Character for the digit at the top of the shift register
    always_comb begin
        if (r_bin_mode) begin
            dig_char = ASCII_ZERO + {7'd0, r_sh[SH_W-1]};
        end else if (top_dig < 4'd10) begin
            dig_char = ASCII_ZERO + {4'd0, top_dig};
        end else begin
            dig_char = ASCII_LETTER_BASE + {4'd0, top_dig};
        end
    end

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_sh        = r_sh;
        n_bin       = r_bin;
        n_cnt       = r_cnt;
        n_bin_mode  = r_bin_mode;
        n_neg       = r_neg;
        n_seen      = r_seen;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_seen     = 1'b0;
                    n_neg      = 1'b0;
                    n_bin_mode = 1'b0;
                    case (i_in_data.func)
                        FUNC_DEC: begin
                            n_neg   = v_in[VALUE_WIDTH-1];
                            n_bin   = v_in[VALUE_WIDTH-1] ? -v_in : v_in;
                            n_sh    = '0;
                            n_cnt   = CNT_W'(VALUE_WIDTH);
                            n_state = S_CONV;
                        end
                        FUNC_BIN: begin
                            n_bin_mode = 1'b1;
                            n_sh       = SH_W'(v_in) << (SH_W - VALUE_WIDTH);
                            n_cnt      = CNT_W'(VALUE_WIDTH);
                            n_state    = S_EMIT;
                        end
                        FUNC_HEX: begin
                            n_sh    = SH_W'(v_in) << (SH_W - HEX_W);
                            n_cnt   = CNT_W'(HEX_W / 4);
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                // one binary bit into the BCD register per cycle
                n_sh  = {adj[SH_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (is_last) begin
                    n_cnt   = CNT_W'(NDIG);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_neg) begin
                        n_neg             = 1'b0;
                        n_out.char_code   = ASCII_MINUS;
                        n_out.last        = 1'b0;
                        n_out_valid       = 1'b1;
                    end else begin
                        // leading zeros are dropped, the final digit never
                        if (r_seen || is_last ||
                            (r_bin_mode ? r_sh[SH_W-1] : top_dig != 4'd0)) begin
                            n_seen          = 1'b1;
                            n_out.char_code = dig_char;
                            n_out.last      = is_last;
                            n_out_valid     = 1'b1;
                        end
                        n_sh  = r_bin_mode ? (r_sh << 1) : (r_sh << 4);
                        n_cnt = r_cnt - CNT_W'(1);
                        if (is_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sh        <= n_sh;
            r_bin       <= n_bin;
            r_cnt       <= n_cnt;
            r_bin_mode  <= n_bin_mode;
            r_neg       <= n_neg;
            r_seen      <= n_seen;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/iaf_checker.sv -----
// Port-level checks for the integer-to-ASCII formatter, bound to the top.
// Depends on iaf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iaf_port_checks
    import iaf_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_req o_out_data
);

    logic out_held;
    logic char_ok;
    logic minus_out;
    logic fmt_taken;

    // terms used by the properties below
    assign out_held  = o_out_valid && i_out_stall;
    assign char_ok   = (o_out_data.char_code >= ASCII_ZERO &&
                        o_out_data.char_code <= ASCII_NINE) ||
                       (o_out_data.char_code >= ASCII_UPPER_A &&
                        o_out_data.char_code <= ASCII_UPPER_F) ||
                       (o_out_data.char_code == ASCII_MINUS);
    assign minus_out = o_out_valid && (o_out_data.char_code == ASCII_MINUS);
    assign fmt_taken = i_in_valid && !o_in_stall && (i_in_data.func != FUNC_UNUSED);

    // a held character stays put
    `ASSERT_CLK(a_out_hold, out_held |=> o_out_valid && $stable(o_out_data), "held output changed")

    // only digits, A-F or minus ever leave
    `ASSERT_CLK(a_char_set, o_out_valid |-> char_ok, "illegal character")

    // the sign is never the final character
    `ASSERT_CLK(a_minus_not_last, minus_out |-> !o_out_data.last, "minus marked last")

    // a valid format request makes the block busy
    `ASSERT_CLK(a_busy_after_req, fmt_taken |=> o_in_stall, "not busy after request")

    // reset empties the output register
    `ASSERT_ALL(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind integer_to_ascii_formatter iaf_port_checks u_iaf_checker (.*);

// ----- sim/iaf_checker.sv -----
// Checker for the integer-to-ASCII formatter: predicts the characters of each number request.
// It compares them with the output requests and counts mismatches.
// Depends on iaf_pkg; instantiated beside the block by tb_top.
module iaf_checker
    import iaf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_data,
    output int       o_fail_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Characters still owed by the block, oldest first
    t_out_req owed_chars[$];
    int       fail_count = 0;

    assign o_fail_count = fail_count;

    // Append the text of one number request to the owed characters
    task automatic predict_text(input t_in_req req);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [31:0] digit;
        logic [7:0]  digit_buf [0:31];
        int          n;
        t_out_req    ch;
        n   = 0;
        mag = req.value;
        case (req.func)
            FUNC_DEC: begin
                radix = 32'd10;
                // negative: sign first, then the magnitude modulo 2^32
                if (mag[31]) begin
                    mag          = ~mag + 32'd1;
                    ch.char_code = ASCII_MINUS;
                    ch.last      = 1'b0;
                    owed_chars.push_back(ch);
                end
            end
            FUNC_BIN: radix = 32'd2;
            FUNC_HEX: radix = 32'd16;
            default:  return;   // unused selector gives no text
        endcase
        // digits least significant first, leading zeros never generated
        do begin
            digit        = mag % radix;
            digit_buf[n] = (digit < 32'd10) ? ASCII_ZERO + digit[7:0]
                                            : ASCII_LETTER_BASE + digit[7:0];
            n++;
            mag = mag / radix;
        end while (mag != 32'd0);
        for (int i = n - 1; i >= 0; i--) begin
            ch.char_code = digit_buf[i];
            ch.last      = (i == 0);
            owed_chars.push_back(ch);
        end
    endtask

    // Compare output requests first, then take in the new number request
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_chars.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected character: expected none, actual %h/%b",
                             $realtime, i_out_data.char_code, i_out_data.last);
                end else begin
                    want = owed_chars.pop_front();
                    if (i_out_data.char_code !== want.char_code ||
                        i_out_data.last !== want.last) begin
                        fail_count++;
                        $display("%0t: character mismatch: expected %h/%b, actual %h/%b",
                                 $realtime, want.char_code, want.last,
                                 i_out_data.char_code, i_out_data.last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_text(i_in_data);
        end
        o_pending <= owed_chars.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the integer-to-ASCII formatter: clock, reset, number requests, output stalls.
// It also gives the verdict.
// Depends on iaf_pkg, integer_to_ascii_formatter and iaf_checker.
module tb_top;
    import iaf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RANDOM_NUMS   = 380;
    localparam int         DRAIN_CYCLES  = 80;
    localparam int         RUN_LIMIT_NS  = 10_000_000;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_data   = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_data;
    int       fail_count;
    int       pending;
    logic     calm = 1'b0;   // no idling on either side while set

    integer_to_ascii_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    iaf_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one number request after a random gap and hold it until taken
    task automatic send_number(input logic [1:0] func, input logic [31:0] value);
        int gap;
        t_in_req req;
        gap       = calm ? 0 : $urandom_range(0, 9);
        req.func  = func;
        req.value = value;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Values of every length, with the extremes and short negatives well represented
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom();
            2:    v = $urandom() >> $urandom_range(1, 31);
            3:    v = -($urandom() >> $urandom_range(4, 31));
            4: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            default: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
        endcase
        return v;
    endfunction

    // Output side: a random stall after each character taken
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall)
                stall_left = calm ? 0 : $urandom_range(0, 9);
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Number requests: directed corners, then random ones
    initial begin
        int          done;
        int          sel;
        logic [1:0]  func;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // decimal corners: zero, one digit, ten digits, most negative
        send_number(FUNC_DEC, 32'd0);
        send_number(FUNC_DEC, 32'd9);
        send_number(FUNC_DEC, 32'd10);
        send_number(FUNC_DEC, 32'd1_000_000_000);
        send_number(FUNC_DEC, 32'h7FFF_FFFF);
        send_number(FUNC_DEC, 32'h8000_0000);
        send_number(FUNC_DEC, 32'hFFFF_FFFF);
        send_number(FUNC_DEC, -32'd1_000_000_000);
        // binary corners
        send_number(FUNC_BIN, 32'd0);
        send_number(FUNC_BIN, 32'd1);
        send_number(FUNC_BIN, 32'h8000_0000);
        send_number(FUNC_BIN, 32'hFFFF_FFFF);
        send_number(FUNC_BIN, 32'h5555_AAAA);
        // hex corners, all letters
        send_number(FUNC_HEX, 32'd0);
        send_number(FUNC_HEX, 32'h0000_000F);
        send_number(FUNC_HEX, 32'hABCD_EF01);
        send_number(FUNC_HEX, 32'hFFFF_FFFF);
        send_number(FUNC_HEX, 32'h1000_0000);
        // unused selector gives nothing, then a normal number behind it
        send_number(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_number(FUNC_UNUSED, 32'd0);
        send_number(FUNC_DEC, 32'd42);

        done = 0;
        while (done < RANDOM_NUMS) begin
            if (done % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 19);
            if (sel == 19)
                func = FUNC_UNUSED;
            else if (sel % 3 == 0)
                func = FUNC_DEC;
            else if (sel % 3 == 1)
                func = FUNC_BIN;
            else
                func = FUNC_HEX;
            send_number(func, pick_value());
            if (func != FUNC_UNUSED)
                done++;
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // let the checker see the last request, drain, then allow for stragglers
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
